// ===== src/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants of the box average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

  localparam int CFG_W      = 13;   // width of the size registers and write data
  localparam int FACTOR_W   = 5;
  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 3;    // counts the quotient bits of one average

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd2;

  localparam logic [CFG_W-1:0]    RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0]    RST_HEIGHT = 13'd480;
  localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [CFG_W-1:0]    source_width;
    logic [CFG_W-1:0]    source_height;
    logic [FACTOR_W-1:0] scale_factor;
  } cfg_regs_t;

  typedef struct packed {
    logic               nonempty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef enum logic {
    FRONT_RUN,
    FRONT_REDIV
  } front_state_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/bda_front.sv =====
// ----------------------------------------------------------------------------
// bda_front
// Pixel intake: tracks raster and block position, accumulates block sums in
// the column sum memory and pushes finished blocks into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16,
  parameter int E_W        = 27
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bda_pkg::cfg_regs_t       cfg,
  input  wire logic                     factor_wr,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [bda_pkg::PIX_W-1:0] in_pixel_in,
  input  wire bda_pkg::q_status_t       q_stat,
  output logic                          q_push,
  output logic [E_W-1:0]                q_wdata
);
  import bda_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W  = $clog2(MAX_WIDTH + 1);
  localparam int WC_W  = (WV_W > CFG_W) ? WV_W : CFG_W;
  localparam int F_W   = $clog2(MAX_FACTOR + 1);
  localparam int FC_W  = (F_W > FACTOR_W) ? F_W : FACTOR_W;
  localparam int OFS_W = $clog2(MAX_FACTOR);
  localparam int RPS_W = $clog2(MAX_FACTOR * PIX_MAX + 1);
  localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * PIX_MAX + 1);
  localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int DC_W  = $clog2(COL_W + 1);

  front_state_t state_r, state_nxt;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [OFS_W-1:0] ox_r, ox_nxt;
  logic [OFS_W-1:0] oy_r, oy_nxt;
  logic [RPS_W-1:0] psum_r, psum_nxt;
  logic [COL_W-1:0] bx_r, bx_nxt;      // column_position / factor
  logic [OFS_W-1:0] cm_r, cm_nxt;      // column_position % factor

  logic [COL_W-1:0] dq_r, dq_nxt;
  logic [F_W-1:0]   drem_r, drem_nxt;
  logic [DC_W-1:0]  dcnt_r, dcnt_nxt;

  // second stage: read-modify-write of one column sum
  logic             b_valid_r;
  logic [COL_W-1:0] b_idx_r;
  logic [RPS_W-1:0] b_add_r;
  logic             b_zero_r;
  logic [CNT_W-1:0] b_cnt_r;
  logic             b_emit_r;
  logic             b_rowend_r;
  logic             b_imgend_r;
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;
  logic [SUM_W-1:0] mem_q_r;
  logic [SUM_W-1:0] column_sums [MAX_WIDTH];

  logic [WC_W-1:0]  w_ext, w_cl;
  logic [CFG_W-1:0] h_cl;
  logic [FC_W-1:0]  f_ext, f_cl, f_last;
  logic             last_col, last_row, end_x, end_y;
  logic             acc_in;
  logic [RPS_W-1:0] psum_add;
  logic [OFS_W:0]   ox1, oy1;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] base_b, acc_b;
  logic [F_W:0]     rem_sh, f_div;
  logic             rem_ge;
  logic [F_W-1:0]   rem_new;
  logic [COL_W-1:0] dq_sh;

  // clamp the registers to their working ranges
  always_comb begin
    w_ext = WC_W'(cfg.source_width);
    if (w_ext == '0) begin
      w_cl = WC_W'(1);
    end else if (w_ext > WC_W'(MAX_WIDTH)) begin
      w_cl = WC_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (cfg.source_height == '0) begin
      h_cl = CFG_W'(1);
    end else if (cfg.source_height > CFG_W'(MAX_HEIGHT)) begin
      h_cl = CFG_W'(MAX_HEIGHT);
    end else begin
      h_cl = cfg.source_height;
    end
    f_ext = FC_W'(cfg.scale_factor);
    if (f_ext == '0) begin
      f_cl = FC_W'(1);
    end else if (f_ext > FC_W'(MAX_FACTOR)) begin
      f_cl = FC_W'(MAX_FACTOR);
    end else begin
      f_cl = f_ext;
    end
    f_last = f_cl - FC_W'(1);
  end

  assign last_col = WC_W'(col_r) >= (w_cl - WC_W'(1));
  assign last_row = CFG_W'(row_r) >= (h_cl - CFG_W'(1));
  assign end_x    = last_col || (FC_W'(ox_r) >= f_last);
  assign end_y    = last_row || (FC_W'(oy_r) >= f_last);
  assign psum_add = psum_r + RPS_W'(in_pixel_in);
  assign ox1      = {1'b0, ox_r} + (OFS_W+1)'(1);
  assign oy1      = {1'b0, oy_r} + (OFS_W+1)'(1);
  assign cnt      = CNT_W'(ox1 * oy1);

  // hold off intake while the factor changes and while the queue may fill up
  assign in_stall = (state_r == FRONT_REDIV) || factor_wr
                 || ((Q_CNT_W+1)'(q_stat.count) + (Q_CNT_W+1)'(b_emit_r && b_valid_r)
                     >= (Q_CNT_W+1)'(Q_DEPTH));
  assign acc_in   = in_valid && !in_stall;

  // one restoring step of column_position / factor
  assign f_div   = (F_W+1)'(f_cl);
  assign rem_sh  = {drem_r, dq_r[COL_W-1]};
  assign rem_ge  = rem_sh >= f_div;
  assign rem_new = rem_ge ? F_W'(rem_sh - f_div) : F_W'(rem_sh);
  assign dq_sh   = {dq_r[COL_W-2:0], rem_ge};

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    psum_nxt  = psum_r;
    bx_nxt    = bx_r;
    cm_nxt    = cm_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dcnt_nxt  = dcnt_r;
    unique case (state_r)
      FRONT_RUN: begin
        if (factor_wr) begin
          state_nxt = FRONT_REDIV;
          dq_nxt    = col_r;
          drem_nxt  = '0;
          dcnt_nxt  = DC_W'(COL_W);
        end else if (acc_in) begin
          psum_nxt = end_x ? '0 : psum_add;
          ox_nxt   = end_x ? '0 : ox_r + OFS_W'(1);
          if (last_col) begin
            col_nxt = '0;
            bx_nxt  = '0;
            cm_nxt  = '0;
            if (last_row) begin
              row_nxt = '0;
              oy_nxt  = '0;
            end else begin
              row_nxt = row_r + ROW_W'(1);
              oy_nxt  = end_y ? '0 : oy_r + OFS_W'(1);
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
            if (FC_W'(cm_r) >= f_last) begin
              cm_nxt = '0;
              bx_nxt = bx_r + COL_W'(1);
            end else begin
              cm_nxt = cm_r + OFS_W'(1);
            end
          end
        end
      end
      FRONT_REDIV: begin
        dq_nxt   = dq_sh;
        drem_nxt = rem_new;
        dcnt_nxt = dcnt_r - DC_W'(1);
        if (dcnt_r == DC_W'(1)) begin
          state_nxt = FRONT_RUN;
          bx_nxt    = dq_sh;
          cm_nxt    = OFS_W'(rem_new);
        end
      end
      default: state_nxt = FRONT_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FRONT_RUN;
      col_r   <= '0;
      row_r   <= '0;
      ox_r    <= '0;
      oy_r    <= '0;
      psum_r  <= '0;
      bx_r    <= '0;
      cm_r    <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
      psum_r  <= psum_nxt;
      bx_r    <= bx_nxt;
      cm_r    <= cm_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
  end

  // base of the column sum: zero on the first row of a block row,
  // else the stored value, or the value being written when it was read
  assign base_b  = b_zero_r ? '0 : (fwd_hit_r ? fwd_data_r : mem_q_r);
  assign acc_b   = base_b + SUM_W'(b_add_r);
  assign q_push  = b_valid_r && b_emit_r;
  assign q_wdata = {acc_b, b_cnt_r, b_rowend_r, b_imgend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc_in && end_x;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && end_x) begin
      b_idx_r    <= bx_r;
      b_add_r    <= psum_add;
      b_zero_r   <= (oy_r == '0);
      b_cnt_r    <= cnt;
      b_emit_r   <= end_y;
      b_rowend_r <= last_col;
      b_imgend_r <= last_col && last_row;
      fwd_hit_r  <= b_valid_r && (b_idx_r == bx_r);
      fwd_data_r <= acc_b;
      mem_q_r    <= column_sums[bx_r];
    end
    if (b_valid_r) begin
      column_sums[b_idx_r] <= acc_b;
    end
  end

endmodule

`default_nettype wire

// ===== src/bda_queue.sv =====
// ----------------------------------------------------------------------------
// bda_queue
// Short FIFO of finished block sums between intake and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_queue #(
  parameter int E_W = 27
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [E_W-1:0]     wdata,
  input  wire logic               pop,
  output logic [E_W-1:0]          rdata,
  output bda_pkg::q_status_t      stat
);
  import bda_pkg::*;

  logic [E_W-1:0]     entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign rdata         = entry_r[rd_ptr_r];
  assign stat.count    = count_r;
  assign stat.nonempty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/bda_back.sv =====
// ----------------------------------------------------------------------------
// bda_back
// Rounded block average (2*sum+count)/(2*count), one quotient bit a cycle,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_back #(
  parameter int MAX_FACTOR = 16,
  parameter int E_W        = 27
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bda_pkg::q_status_t        q_stat,
  input  wire logic [E_W-1:0]            q_rdata,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [bda_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_row_end,
  output logic                           out_image_end
);
  import bda_pkg::*;

  localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * PIX_MAX + 1);
  localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int NUM_W = SUM_W + 2;
  localparam int DSH_W = CNT_W + PIX_W;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

  back_state_t state_r, state_nxt;

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [PIX_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              re_r, re_nxt;
  logic              ie_r, ie_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_re_r;
  logic              out_ie_r;
  logic              out_load;

  logic [SUM_W-1:0]  q_sum;
  logic [CNT_W-1:0]  q_cnt;
  logic              q_re, q_ie;
  logic              ge;
  logic              out_free;

  assign q_sum = q_rdata[E_W-1 -: SUM_W];
  assign q_cnt = q_rdata[CNT_W+1:2];
  assign q_re  = q_rdata[1];
  assign q_ie  = q_rdata[0];

  assign ge       = CMP_W'(rem_r) >= CMP_W'(dsh_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    re_nxt    = re_r;
    ie_nxt    = ie_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BACK_IDLE: begin
        if (q_stat.nonempty) begin
          q_pop     = 1'b1;
          rem_nxt   = NUM_W'({q_sum, 1'b0}) + NUM_W'(q_cnt);
          dsh_nxt   = {q_cnt, 1'b0, (PIX_W-1)'(0)};
          quo_nxt   = '0;
          step_nxt  = STEP_W'(PIX_W - 1);
          re_nxt    = q_re;
          ie_nxt    = q_ie;
          state_nxt = BACK_DIV;
        end
      end
      BACK_DIV: begin
        if (ge) begin
          rem_nxt = NUM_W'(CMP_W'(rem_r) - CMP_W'(dsh_r));
        end
        quo_nxt  = {quo_r[PIX_W-2:0], ge};
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = BACK_HOLD;
        end
      end
      BACK_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = BACK_IDLE;
        end
      end
      default: state_nxt = BACK_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BACK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    re_r  <= re_nxt;
    ie_r  <= ie_nxt;
    if (out_load) begin
      out_pix_r <= quo_r;
      out_re_r  <= re_r;
      out_ie_r  <= ie_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_row_end   = out_re_r;
  assign out_image_end = out_ie_r;

endmodule

`default_nettype wire

// ===== src/box_average_downscaler.sv =====
// ----------------------------------------------------------------------------
// box_average_downscaler
// Averages each scale_factor x scale_factor block of a raster image into one
// output pixel, rounded half up; blocks cut by the image edge are averaged
// over the pixels they hold.
//
// Input: in_pixel_in, one pixel per item in raster order (in_valid/in_stall).
// Output: out_pixel_out with out_row_end and out_image_end flags
// (out_valid/out_stall), one item per finished block.
// Config: cfg_we/cfg_index/cfg_wdata write width, height and factor.
// Intake takes one pixel per cycle except while it is stalled, during a
// factor change or when the queue may fill; the divider works on one
// block at a time (pop, 8 quotient bits, output load) and takes no new
// block before its result is loaded into the output register.
// A write of scale_factor stalls intake while the block column index is
// recomputed by a serial divider.
// A four-entry queue decouples intake and divider; a stalled output holds
// its item and intake keeps running until the queue fills.
// Reset zeroes all position counters and loads 640 x 480, factor 2; the
// column sum memory is not cleared, the first row of each block row
// overwrites it.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downscaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bda_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bda_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bda_pkg::PIX_W-1:0]          out_pixel_out,
  output logic                               out_row_end,
  output logic                               out_image_end
);
  import bda_pkg::*;

  localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * PIX_MAX + 1);
  localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int E_W   = SUM_W + CNT_W + 2;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      factor_wr;
  logic      q_push, q_pop;
  logic [E_W-1:0] q_wdata, q_rdata;
  q_status_t q_stat;

  assign factor_wr = cfg_we && (cfg_index == CFG_IDX_FACTOR);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  cfg_nxt.source_width  = cfg_wdata;
        CFG_IDX_HEIGHT: cfg_nxt.source_height = cfg_wdata;
        CFG_IDX_FACTOR: cfg_nxt.scale_factor  = cfg_wdata[FACTOR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= RST_WIDTH;
      cfg_r.source_height <= RST_HEIGHT;
      cfg_r.scale_factor  <= RST_FACTOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bda_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .E_W        (E_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .factor_wr   (factor_wr),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  bda_queue #(
    .E_W (E_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  bda_back #(
    .MAX_FACTOR (MAX_FACTOR),
    .E_W        (E_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end)
  );

`ifndef ASSERT_OFF
  // a push never lands on a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ((q_stat.count < Q_CNT_W'(Q_DEPTH)) || q_pop))
    else $error("queue overflow");

  // the last block of the image is also the last of its row
  a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_end) |-> out_row_end)
    else $error("image_end without row_end");

  // a factor write holds off intake while the column index is recomputed
  a_factor_stall: assert property (@(posedge clk) disable iff (!rst_n)
    factor_wr |=> in_stall)
    else $error("intake not stalled after factor write");
`endif

endmodule

`default_nettype wire
